>>> sv/hexv_pkg.sv
package hexv_pkg;

  // Coordinate width, signed fixed point with 8 fractional bits.
  localparam int COORD_BITS = 16;

  // Datapath widths. Points are scaled by 8 so that the face and body centers stay exact.
  localparam int SUM_W      = COORD_BITS + 3;        // sum of eight corners
  localparam int DIFF_W     = COORD_BITS + 4;        // edge vector component
  localparam int PROD_W     = 2 * DIFF_W;            // v * w
  localparam int CROSS_W    = PROD_W + 1;            // v * w - v * w
  localparam int UN_W       = DIFF_W + 1;            // u, possibly negated
  localparam int TERM_W     = CROSS_W + UN_W;        // one term of a triple product
  localparam int DIV_W      = TERM_W + (TERM_W % 2); // dividend of the divide by three
  localparam int RND_SHIFT  = 10;                    // 3072 = 3 * 2^10
  localparam int ACC_W      = DIV_W + RND_SHIFT;     // 72 terms need 7 guard bits
  localparam int DIV_STEPS  = DIV_W / 2;             // two quotient bits per cycle
  localparam int VOL_W      = 64;
  localparam int QZ_W       = (DIV_W > VOL_W) ? DIV_W : VOL_W + 1;
  localparam int RND_HALF   = 1536;

  localparam int NUM_CORNER = 8;
  localparam int CORNER_W   = 3;
  localparam int NUM_TET    = 24;
  localparam int TET_W      = 5;
  localparam int NUM_FACE   = 6;
  localparam int FACE_W     = 3;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int CNT_MAX    = (DIV_STEPS > NUM_TET) ? DIV_STEPS : NUM_TET;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNER - 1);

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic                wr;       // store the incoming corner
    logic                sum_clr;  // clear centers and accumulator
    logic                sum_rd;   // read corner addr_a for the center sums
    logic                tet_rd;   // read both corners of a tetrahedron
    logic [CORNER_W-1:0] addr_a;
    logic [CORNER_W-1:0] addr_b;
    logic                uvw_ld;   // form the edge vectors u, v and w
    logic [FACE_W-1:0]   face;
    logic                term_en;  // start one triple product term
    logic [1:0]          term_k;
    logic                abs_en;
    logic                rnd_en;
    logic                div_en;
    logic                sgn_en;
    logic                out_ld;
  } cmd_t;

  // Tetrahedron table: two corners of a face edge and the face index.
  function automatic logic [2*CORNER_W+FACE_W-1:0] tet_entry(input logic [TET_W-1:0] t);
    logic [2*CORNER_W+FACE_W-1:0] r;
    case (t)
      5'd0:  r = {3'd0, 3'd1, 3'd0};
      5'd1:  r = {3'd1, 3'd2, 3'd0};
      5'd2:  r = {3'd2, 3'd3, 3'd0};
      5'd3:  r = {3'd3, 3'd0, 3'd0};
      5'd4:  r = {3'd0, 3'd3, 3'd1};
      5'd5:  r = {3'd3, 3'd7, 3'd1};
      5'd6:  r = {3'd7, 3'd4, 3'd1};
      5'd7:  r = {3'd4, 3'd0, 3'd1};
      5'd8:  r = {3'd0, 3'd4, 3'd2};
      5'd9:  r = {3'd4, 3'd5, 3'd2};
      5'd10: r = {3'd5, 3'd1, 3'd2};
      5'd11: r = {3'd1, 3'd0, 3'd2};
      5'd12: r = {3'd1, 3'd5, 3'd3};
      5'd13: r = {3'd5, 3'd6, 3'd3};
      5'd14: r = {3'd6, 3'd2, 3'd3};
      5'd15: r = {3'd2, 3'd1, 3'd3};
      5'd16: r = {3'd2, 3'd6, 3'd4};
      5'd17: r = {3'd6, 3'd7, 3'd4};
      5'd18: r = {3'd7, 3'd3, 3'd4};
      5'd19: r = {3'd3, 3'd2, 3'd4};
      5'd20: r = {3'd6, 3'd5, 3'd5};
      5'd21: r = {3'd5, 3'd4, 3'd5};
      5'd22: r = {3'd4, 3'd7, 3'd5};
      5'd23: r = {3'd7, 3'd6, 3'd5};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Faces that contain a given corner, one bit per face.
  function automatic logic [NUM_FACE-1:0] face_mask(input logic [CORNER_W-1:0] c);
    logic [NUM_FACE-1:0] m;
    case (c)
      3'd0: m = 6'b000111;
      3'd1: m = 6'b001101;
      3'd2: m = 6'b011001;
      3'd3: m = 6'b010011;
      3'd4: m = 6'b100110;
      3'd5: m = 6'b101100;
      3'd6: m = 6'b111000;
      3'd7: m = 6'b110010;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> sv/hexv_ctrl.sv
module hexv_ctrl
  import hexv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CORNER_W-1:0] corner,
  output logic                out_valid,
  input  logic                out_ready,
  output cmd_t                cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_TET   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_RND   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SGN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(NUM_CORNER);
  localparam logic [CNT_W-1:0] TET_LAST  = CNT_W'(NUM_TET - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] DRAIN_END = CNT_W'(1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [2:0]       step, step_next;
  logic             out_valid_next;
  logic             accept;
  logic [2*CORNER_W+FACE_W-1:0] tet;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign tet      = tet_entry(cnt[TET_W-1:0]);

  always_comb begin
    cmd        = '0;
    cmd.wr     = accept;
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (accept && corner == LAST_CORNER) begin
          cmd.sum_clr = 1'b1;
          state_next  = S_SUM;
          cnt_next    = '0;
        end
      end
      S_SUM: begin
        if (cnt == SUM_LAST) begin
          state_next = S_TET;
          cnt_next   = '0;
          step_next  = '0;
        end else begin
          cmd.sum_rd = 1'b1;
          cmd.addr_a = cnt[CORNER_W-1:0];
          cnt_next   = cnt + 1'b1;
        end
      end
      S_TET: begin
        cmd.addr_a = tet[2*CORNER_W+FACE_W-1 -: CORNER_W];
        cmd.addr_b = tet[CORNER_W+FACE_W-1 -: CORNER_W];
        cmd.face   = tet[FACE_W-1:0];
        case (step)
          3'd0: cmd.tet_rd = 1'b1;
          3'd1: cmd.uvw_ld = 1'b1;
          default: begin
            cmd.term_en = 1'b1;
            cmd.term_k  = 2'(step - 3'd2);
          end
        endcase
        if (step == 3'd4) begin
          step_next = '0;
          if (cnt == TET_LAST) begin
            state_next = S_DRAIN;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cnt == DRAIN_END) begin
          state_next = S_ABS;
        end
        cnt_next = cnt + 1'b1;
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_SGN;
        end
      end
      S_SGN: begin
        cmd.sgn_en = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_ld) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && corner == LAST_CORNER) |=> (state == S_SUM))
    else $error("corner 7 did not start the volume computation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || out_ready))
    else $error("result register loaded while a result was pending");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sum_rd, cmd.tet_rd, cmd.uvw_ld, cmd.term_en, cmd.div_en}))
    else $error("conflicting datapath commands");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == DIV_LAST) |=> (state == S_SGN))
    else $error("divider step count broken");

endmodule

>>> sv/hexv_dp.sv
module hexv_dp
  import hexv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic [CORNER_W-1:0]          corner,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic                         last_element,
  output logic signed [VOL_W-1:0]      element_volume,
  output logic signed [VOL_W-1:0]      mesh_volume,
  output logic                         mesh_done
);

  localparam logic signed [VOL_W-1:0] VMAX = {1'b0, {(VOL_W-1){1'b1}}};
  localparam logic signed [VOL_W-1:0] VMIN = {1'b1, {(VOL_W-1){1'b0}}};

  function automatic logic [1:0] div3_q(input logic [3:0] c);
    logic [1:0] q;
    if (c >= 4'd9) q = 2'd3;
    else if (c >= 4'd6) q = 2'd2;
    else if (c >= 4'd3) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  logic [PT_W-1:0] mem [NUM_CORNER];
  logic [PT_W-1:0] qa, qb;

  logic signed [SUM_W-1:0]  ctr [3];
  logic signed [SUM_W-1:0]  fs  [NUM_FACE][3];
  logic                     sum_vld;
  logic [CORNER_W-1:0]      sum_addr;
  logic [NUM_FACE-1:0]      sum_mask;

  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [DIFF_W-1:0] w [3];

  logic signed [DIFF_W-1:0] ma_x, ma_y, mb_x, mb_y, us;
  logic                     us_neg;
  logic signed [PROD_W-1:0] pa, pb;
  logic signed [UN_W-1:0]   un1;
  logic                     t1v;
  logic signed [CROSS_W-1:0] xd;
  logic signed [TERM_W-1:0] q;
  logic                     t2v;
  logic signed [ACC_W-1:0]  acc;

  logic                     neg;
  logic [ACC_W-1:0]         mag, mg;
  logic [DIV_W-1:0]         dq;
  logic [1:0]               rem;
  logic [3:0]               cur;
  logic [1:0]               qd;
  logic [QZ_W-1:0]          qz;
  logic                     big;
  logic signed [VOL_W-1:0]  vol;
  logic signed [VOL_W-1:0]  mesh_sum;
  logic signed [VOL_W-1:0]  tsum, total;
  logic                     last_r;

  // Corner store: written on accept, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[corner] <= {coord_z, coord_y, coord_x};
    end
    if (cmd.sum_rd || cmd.tet_rd) begin
      qa <= mem[cmd.addr_a];
      qb <= mem[cmd.addr_b];
    end
    if (cmd.wr && corner == LAST_CORNER) begin
      last_r <= last_element;
    end
  end

  assign sum_mask = face_mask(sum_addr);

  // Body center and face sums, one corner a cycle.
  always_ff @(posedge clk) begin
    sum_vld  <= cmd.sum_rd;
    sum_addr <= cmd.addr_a;
    for (int a = 0; a < 3; a++) begin
      if (cmd.sum_clr) begin
        ctr[a] <= '0;
        for (int f = 0; f < NUM_FACE; f++) fs[f][a] <= '0;
      end else if (sum_vld) begin
        ctr[a] <= ctr[a] + SUM_W'($signed(qa[a*COORD_BITS +: COORD_BITS]));
        for (int f = 0; f < NUM_FACE; f++) begin
          if (sum_mask[f]) begin
            fs[f][a] <= fs[f][a] + SUM_W'($signed(qa[a*COORD_BITS +: COORD_BITS]));
          end
        end
      end
    end
  end

  // Edge vectors from the body center, all scaled by 8.
  always_ff @(posedge clk) begin
    if (cmd.uvw_ld) begin
      for (int a = 0; a < 3; a++) begin
        u[a] <= (DIFF_W'($signed(qa[a*COORD_BITS +: COORD_BITS])) <<< 3) - DIFF_W'(ctr[a]);
        v[a] <= (DIFF_W'($signed(qb[a*COORD_BITS +: COORD_BITS])) <<< 3) - DIFF_W'(ctr[a]);
        w[a] <= (DIFF_W'(fs[cmd.face][a]) <<< 1) - DIFF_W'(ctr[a]);
      end
    end
  end

  // Term k of the triple product: sign * u[k] * (pa - pb).
  always_comb begin
    case (cmd.term_k)
      2'd0: begin
        ma_x = v[1]; ma_y = w[2]; mb_x = v[2]; mb_y = w[1]; us = u[0]; us_neg = 1'b1;
      end
      2'd1: begin
        ma_x = v[0]; ma_y = w[2]; mb_x = v[2]; mb_y = w[0]; us = u[1]; us_neg = 1'b0;
      end
      default: begin
        ma_x = v[0]; ma_y = w[1]; mb_x = v[1]; mb_y = w[0]; us = u[2]; us_neg = 1'b1;
      end
    endcase
  end

  assign xd = CROSS_W'(pa) - CROSS_W'(pb);

  always_ff @(posedge clk) begin
    t1v <= cmd.term_en;
    t2v <= t1v;
    if (cmd.term_en) begin
      pa  <= ma_x * ma_y;
      pb  <= mb_x * mb_y;
      un1 <= us_neg ? -UN_W'(us) : UN_W'(us);
    end
    if (t1v) begin
      q <= un1 * xd;
    end
    if (cmd.sum_clr) begin
      acc <= '0;
    end else if (t2v) begin
      acc <= acc + ACC_W'(q);
    end
  end

  // Divide by 3072 with rounding half away from zero: magnitude, add half,
  // drop ten bits, then divide by three two bits a cycle.
  assign mg  = mag + ACC_W'(RND_HALF);
  assign cur = {rem, dq[DIV_W-1 -: 2]};
  assign qd  = div3_q(cur);
  assign qz  = QZ_W'(dq);
  assign big = |qz[QZ_W-1:VOL_W-1];

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
    if (cmd.rnd_en) begin
      dq  <= mg[ACC_W-1:RND_SHIFT];
      rem <= '0;
    end else if (cmd.div_en) begin
      dq  <= {dq[DIV_W-3:0], qd};
      rem <= 2'(cur - 4'(qd) * 4'd3);
    end
    if (cmd.sgn_en) begin
      if (big) begin
        vol <= neg ? VMIN : VMAX;
      end else begin
        vol <= neg ? -$signed(qz[VOL_W-1:0]) : $signed(qz[VOL_W-1:0]);
      end
    end
  end

  // Saturating running total and the result register.
  assign tsum  = mesh_sum + vol;
  assign total = (mesh_sum[VOL_W-1] == vol[VOL_W-1] && tsum[VOL_W-1] != vol[VOL_W-1])
                 ? (vol[VOL_W-1] ? VMIN : VMAX) : tsum;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      element_volume <= vol;
      mesh_volume    <= total;
      mesh_done      <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_sum <= '0;
    end else if (cmd.out_ld) begin
      mesh_sum <= last_r ? '0 : total;
    end
  end

endmodule

>>> sv/hexahedron_volume_unit.sv
// Hexahedron volume unit.
// The input channel (in_valid / in_ready) carries one corner request per item:
// the corner number, its x, y and z coordinates in signed Q8.8 and last_element.
// Corners 0 to 6 are only stored in the corner store. Corner 7 starts the
// volume computation and produces one result request on the output channel
// (out_valid / out_ready): the element volume and the running mesh total, both
// signed with 24 fractional bits and saturated, and mesh_done, which repeats
// last_element. After a result with mesh_done set the running total restarts at zero.
// From corner 7 to its result the block forms the center sums, works through
// the 24 tetrahedra on two shared 20x20 multipliers feeding a 21x41 multiplier,
// drains that pipeline, takes the magnitude and rounds, divides by three two
// quotient bits at a time and applies the sign. in_ready is low from corner 7
// until the result is loaded, so the corners of the next element wait for it.
// The result sits in an output register; while the receiver stalls the block
// still accepts the corners of the next element, and holds only the finished
// result of that element until the register frees.
// Reset clears the controller, the output valid and the running total; the
// corner store holds no defined values until every corner has been written.
module hexahedron_volume_unit
  import hexv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CORNER_W-1:0]          corner,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic                         last_element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VOL_W-1:0]      element_volume,
  output logic signed [VOL_W-1:0]      mesh_volume,
  output logic                         mesh_done
);

  cmd_t cmd;

  // The controller sequences the center sums, the tetrahedra and the divider.
  hexv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .corner    (corner),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the corner store, the multipliers, the accumulator,
  // the divider and the result register.
  hexv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .corner         (corner),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .last_element   (last_element),
    .element_volume (element_volume),
    .mesh_volume    (mesh_volume),
    .mesh_done      (mesh_done)
  );

endmodule
